// ----- design/mxg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mxg_pkg;

	localparam int WORD_W    = 64;
	localparam int LANES_DEF = 8;

	// request command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_NEXT  = 1'b1;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_ONE = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_TWO = 64'h94D0_49BB_1331_11EB;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEXT_CALC,
		ST_NEXT_EMIT,
		ST_SEED
	} state_t;

	// one splitmix64 word: add, then two 64x64 low-half products built
	// from three 32x32 partial products each
	typedef enum logic [3:0] {
		SP_ADD,
		SP_M1_LL,
		SP_M1_HL,
		SP_M1_LH,
		SP_M1_SUM,
		SP_M2_LL,
		SP_M2_HL,
		SP_M2_LH,
		SP_M2_SUM
	} seed_phase_t;

	function automatic logic [63:0] rotl23(input logic [63:0] x);
		rotl23 = {x[40:0], x[63:41]};
	endfunction

	function automatic logic [63:0] rotl45(input logic [63:0] x);
		rotl45 = {x[18:0], x[63:19]};
	endfunction

endpackage
`default_nettype wire

// ----- design/mxg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mxg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/multilane_xoshiro_generator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// multilane xoshiro256++ generator: LANES independent xoshiro256++ lanes hand out
// 64-bit words in round-robin order, lane 0 first. a start request (cmd = 0) seeds
// all lanes from a 64-bit seed with splitmix64, four words per lane (a, b, c, d),
// resets the lane pointer and returns nothing; it keeps the block busy while all
// lanes are seeded on one shared 32x32 multiplier that builds each 64-bit
// product from three partial products. a next request (cmd = 1) returns
// rotl(a+d,23)+a of the current lane and advances that lane through state memory
// read, update and write-back, and output add; the block takes no new request
// until it is back in idle. the lane states live in one 256-bit wide memory with
// registered read; per-lane valid flops make a lane that was never written read
// as zero, so words are zero until the first start. a request is taken only
// while idle and the output register is free or being drained, which also keeps
// a read from overlapping a write-back.
module multilane_xoshiro_generator_unit #(
	parameter int LANES = mxg_pkg::LANES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      cmd,
	input  wire logic [mxg_pkg::WORD_W-1:0] seed,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [mxg_pkg::WORD_W-1:0] word
);
	import mxg_pkg::*;

	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int SW = 4 * WORD_W;
	localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

	state_t       state_q, state_d;
	seed_phase_t  phase_q;

	// control
	logic [LW-1:0]    ptr_q;
	logic [LW-1:0]    lane_q;
	logic [1:0]       widx_q;
	logic [LANES-1:0] valid_q;
	logic             out_valid_q;

	// datapath
	logic [63:0] acc_q, x_q, res_q, prod_q;
	logic [63:0] wa_q, wb_q, wc_q;
	logic [63:0] sum_q, a_hold_q, word_q;
	logic        rd_valid_s1;

	// control strobes
	logic          accept;
	logic          ram_we;
	logic [LW-1:0] ram_waddr;
	logic          seed_write;
	logic          seed_done;
	logic          next_wb;
	logic          emit;

	// memory ports
	logic [SW-1:0] ram_wdata, ram_rdata;

	// lane update
	logic [63:0] la, lb, lc, ld;
	logic [63:0] na, nb, nc, nd;

	// splitmix64 datapath
	logic [63:0] acc_inc, mix_res, z_out;
	logic [63:0] mul_k;
	logic [31:0] mul_x, mul_kh;

	mxg_ram #(
		.WIDTH(SW),
		.DEPTH(LANES)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// lane read data, zero for a lane never written
	assign la = rd_valid_s1 ? ram_rdata[4*WORD_W-1:3*WORD_W] : '0;
	assign lb = rd_valid_s1 ? ram_rdata[3*WORD_W-1:2*WORD_W] : '0;
	assign lc = rd_valid_s1 ? ram_rdata[2*WORD_W-1:WORD_W]   : '0;
	assign ld = rd_valid_s1 ? ram_rdata[WORD_W-1:0]          : '0;

	// xoshiro256++ state step
	assign nc = lc ^ la ^ {lb[46:0], 17'b0};
	assign nb = lb ^ lc ^ la;
	assign na = la ^ ld ^ lb;
	assign nd = rotl45(ld ^ lb);

	assign ram_wdata = next_wb ? {na, nb, nc, nd} : {wa_q, wb_q, wc_q, z_out};

	// splitmix64: shared 32x32 multiplier, operand halves picked by phase
	assign acc_inc = acc_q + GOLDEN_STEP;
	assign mix_res = res_q + {prod_q[31:0], 32'b0};
	assign z_out   = mix_res ^ (mix_res >> 31);

	always_comb begin
		mul_k  = MIX_MUL_ONE;
		mul_x  = x_q[31:0];
		mul_kh = MIX_MUL_ONE[31:0];
		if (phase_q == SP_M2_LL || phase_q == SP_M2_HL || phase_q == SP_M2_LH) begin
			mul_k = MIX_MUL_TWO;
		end
		if (phase_q == SP_M1_HL || phase_q == SP_M2_HL) begin
			mul_x = x_q[63:32];
		end
		if (phase_q == SP_M1_LH || phase_q == SP_M2_LH) begin
			mul_kh = mul_k[63:32];
		end else begin
			mul_kh = mul_k[31:0];
		end
	end

	assign seed_write = (state_q == ST_SEED) && (phase_q == SP_M2_SUM) && (widx_q == 2'd3);

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = lane_q;
		next_wb   = 1'b0;
		emit      = 1'b0;
		seed_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					state_d = (cmd == CMD_START) ? ST_SEED : ST_NEXT_CALC;
				end
			end
			ST_NEXT_CALC: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				next_wb   = 1'b1;
				state_d   = ST_NEXT_EMIT;
			end
			ST_NEXT_EMIT: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SEED: begin
				if (seed_write) begin
					ram_we = 1'b1;
					if (lane_q == LAST_LANE) begin
						seed_done = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= SP_ADD;
			ptr_q       <= '0;
			lane_q      <= '0;
			widx_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (accept && cmd == CMD_START) begin
				phase_q <= SP_ADD;
				lane_q  <= '0;
				widx_q  <= '0;
			end else if (state_q == ST_SEED) begin
				unique case (phase_q)
					SP_ADD:    phase_q <= SP_M1_LL;
					SP_M1_LL:  phase_q <= SP_M1_HL;
					SP_M1_HL:  phase_q <= SP_M1_LH;
					SP_M1_LH:  phase_q <= SP_M1_SUM;
					SP_M1_SUM: phase_q <= SP_M2_LL;
					SP_M2_LL:  phase_q <= SP_M2_HL;
					SP_M2_HL:  phase_q <= SP_M2_LH;
					SP_M2_LH:  phase_q <= SP_M2_SUM;
					SP_M2_SUM: begin
						phase_q <= SP_ADD;
						widx_q  <= widx_q + 2'd1;
						if (seed_write) begin
							lane_q <= lane_q + 1'b1;
						end
					end
					default:   phase_q <= SP_ADD;
				endcase
			end
			if (seed_done) begin
				ptr_q <= '0;
			end else if (next_wb) begin
				ptr_q <= (ptr_q == LAST_LANE) ? '0 : ptr_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_valid_s1 <= valid_q[ptr_q];
		if (accept && cmd == CMD_START) begin
			acc_q <= seed;
		end
		if (state_q == ST_SEED) begin
			prod_q <= {32'b0, mul_x} * {32'b0, mul_kh};
			unique case (phase_q)
				SP_ADD: begin
					acc_q <= acc_inc;
					x_q   <= acc_inc ^ (acc_inc >> 30);
				end
				SP_M1_HL, SP_M2_HL: begin
					res_q <= prod_q;
				end
				SP_M1_LH, SP_M2_LH: begin
					res_q[63:32] <= res_q[63:32] + prod_q[31:0];
				end
				SP_M1_SUM: begin
					x_q <= mix_res ^ (mix_res >> 27);
				end
				SP_M2_SUM: begin
					unique case (widx_q)
						2'd0:    wa_q <= z_out;
						2'd1:    wb_q <= z_out;
						2'd2:    wc_q <= z_out;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (next_wb) begin
			sum_q    <= la + ld;
			a_hold_q <= la;
		end
		if (emit) begin
			word_q <= rotl23(sum_q) + a_hold_q;
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;

endmodule
`default_nettype wire

// ----- design/mxg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mxg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] word
);
	import mxg_pkg::*;

	// a taken request leaves the block busy, so it is not ready in the next cycle
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken back to back");

	// a next request raises out_valid once it has passed the update and emit states
	a_next_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_NEXT |-> ##3 out_valid)
		else $error("next word missing");

	// no request is taken while a stalled word would be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_ready)
		else $error("request taken over a stalled word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word))
		else $error("stalled word dropped or changed");

endmodule

bind multilane_xoshiro_generator_unit mxg_checker u_mxg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.cmd      (cmd),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.word     (word)
);
`default_nettype wire

// ----- tb/multilane_xoshiro_generator_unit_test.sv -----
`timescale 1ns / 1ps
module multilane_xoshiro_generator_unit_test;

	// lane count and word width follow the block's defaults
	localparam int LANE_COUNT = mxg_pkg::LANES_DEF;
	localparam int W = mxg_pkg::WORD_W;

	// splitmix64 increment and multipliers
	localparam logic [63:0] SM_INC   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SM_MUL_A = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] SM_MUL_B = 64'h94D0_49BB_1331_11EB;

	localparam logic OP_START = mxg_pkg::CMD_START;
	localparam logic OP_NEXT  = mxg_pkg::CMD_NEXT;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 1450;
	// a start keeps the block busy while every lane is seeded, and gaps and stalls
	// add more on top, yet this many silent cycles still means a hang
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int REPORT_MAX    = 10;

	// one row of the directed table; pinned rows carry a word known by inspection
	typedef struct packed {
		logic        op;
		logic [63:0] seed_val;
		bit          pinned;
		logic [63:0] pin_word;
	} stim_row_t;

	typedef struct packed {
		bit          pinned;
		logic [63:0] pin_word;
	} pin_entry_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic         cmd = 1'b0;
	logic [W-1:0] seed = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [W-1:0] word;

	// predictor copy of the lane states and the round-robin pointer
	logic [63:0] lane_a [LANE_COUNT];
	logic [63:0] lane_b [LANE_COUNT];
	logic [63:0] lane_c [LANE_COUNT];
	logic [63:0] lane_d [LANE_COUNT];
	int          lane_ptr;

	// words still owed by the block, oldest first
	logic [63:0] words_due [$];
	// per-request note of a hand-typed word, pushed when the request is driven
	pin_entry_t  pinned_due [$];

	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	int          ready_hold = 0;
	int          ready_stall;
	pin_entry_t  pin;
	logic [63:0] drawn;
	logic [63:0] want;
	bit          any_accept;

	stim_row_t stim_rows [DIRECTED_ROWS] = '{
		// next before any start: all lanes zero, words stay zero, seed ignored
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b1, 64'h0},
		'{OP_NEXT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
		'{OP_NEXT,  64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'h0},
		'{OP_NEXT,  64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 64'h0},
		// zero seed, then a full round plus wrap to lane 0
		'{OP_START, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0001, 1'b0, 64'h0},
		'{OP_NEXT,  64'h8000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
		'{OP_NEXT,  64'hFEDC_BA98_7654_3210, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		// all-ones seed, restart mid-round
		'{OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		// top bit only, pointer must return to lane 0
		'{OP_START, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		// back-to-back starts, the second one wins
		'{OP_START, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
		'{OP_START, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 64'h0},
		'{OP_NEXT,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{OP_NEXT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0}
	};

	multilane_xoshiro_generator_unit #(
		.LANES(LANE_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.seed(seed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.word(word)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] spin_left(input logic [63:0] x, input int k);
		spin_left = (x << k) | (x >> (64 - k));
	endfunction

	// splitmix64 output stage for an already advanced accumulator
	function automatic logic [63:0] splitmix_mix(input logic [63:0] acc);
		logic [63:0] z;
		z = acc;
		z = (z ^ (z >> 30)) * SM_MUL_A;
		z = (z ^ (z >> 27)) * SM_MUL_B;
		splitmix_mix = z ^ (z >> 31);
	endfunction

	// fill every lane from the seed, lane 0 first, words a b c d per lane
	task automatic splitmix_reseed(input logic [63:0] s);
		logic [63:0] acc;
		int k;
		acc = s;
		for (k = 0; k < LANE_COUNT; k++) begin
			acc = acc + SM_INC;
			lane_a[k] = splitmix_mix(acc);
			acc = acc + SM_INC;
			lane_b[k] = splitmix_mix(acc);
			acc = acc + SM_INC;
			lane_c[k] = splitmix_mix(acc);
			acc = acc + SM_INC;
			lane_d[k] = splitmix_mix(acc);
		end
		lane_ptr = 0;
	endtask

	// xoshiro256++ word of the current lane, then step that lane and move on
	task automatic xoshiro_draw(output logic [63:0] w);
		logic [63:0] a, b, c, d, t;
		a = lane_a[lane_ptr];
		b = lane_b[lane_ptr];
		c = lane_c[lane_ptr];
		d = lane_d[lane_ptr];
		w = spin_left(a + d, 23) + a;
		t = b << 17;
		c = c ^ a;
		d = d ^ b;
		b = b ^ c;
		a = a ^ d;
		c = c ^ t;
		d = spin_left(d, 45);
		lane_a[lane_ptr] = a;
		lane_b[lane_ptr] = b;
		lane_c[lane_ptr] = c;
		lane_d[lane_ptr] = d;
		lane_ptr = (lane_ptr + 1 >= LANE_COUNT) ? 0 : lane_ptr + 1;
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// mostly back to back, sometimes short gaps, now and then a long one; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drive one request and hold it until taken; called right after an edge.
	// valid drops only when a gap or a drain comes first, so it is never
	// lowered and raised in the same step
	task automatic send_request(input logic op, input logic [63:0] s, input bit pinned,
			input logic [63:0] pin_word, input int gap, input bit drain);
		if (gap > 0 || drain) begin
			in_valid <= 1'b0;
			if (drain) begin
				@(posedge clk);
				while (words_due.size() != 0)
					@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		pinned_due.push_back('{pinned, pin_word});
		in_valid <= 1'b1;
		cmd <= op;
		seed <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// receiver: ready with random stalls, always ready in calm stretches
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			ready_stall = pick_gap();
			if (ready_stall > 0 && out_ready) begin
				out_ready <= 1'b0;
				ready_hold <= ready_stall - 1;
			end else begin
				out_ready <= 1'b1;
				ready_hold <= calm ? 0 : $urandom_range(0, 7);
			end
		end
	end

	// monitor: predict on each taken request, check each taken word, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			any_accept = 1'b0;
			// check the output first so a word never matches a same-edge request
			if (out_valid && out_ready) begin
				any_accept = 1'b1;
				if (words_due.size() == 0) begin
					note_failure($sformatf("unexpected word %h", word));
				end else begin
					want = words_due.pop_front();
					if (word !== want)
						note_failure($sformatf("word mismatch: expected %h, got %h",
							want, word));
				end
			end
			if (in_valid && in_ready) begin
				any_accept = 1'b1;
				pin = pinned_due.pop_front();
				if (cmd == OP_START) begin
					splitmix_reseed(seed);
				end else begin
					xoshiro_draw(drawn);
					words_due.push_back(pin.pinned ? pin.pin_word : drawn);
				end
			end
			if (any_accept) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	// stimulus
	initial begin
		int i;
		int r;
		logic op;
		logic [63:0] s;
		bit drain;

		for (i = 0; i < LANE_COUNT; i++) begin
			lane_a[i] = '0;
			lane_b[i] = '0;
			lane_c[i] = '0;
			lane_d[i] = '0;
		end
		lane_ptr = 0;

		// hold reset, then release it on a falling edge, away from the rising edge
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_request(stim_rows[i].op, stim_rows[i].seed_val, stim_rows[i].pinned,
				stim_rows[i].pin_word, pick_gap(), 1'b0);

		// random part: long runs of next requests with an occasional restart
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 2) == 0);
			op = ($urandom_range(0, 39) == 0) ? OP_START : OP_NEXT;
			r = $urandom_range(0, 99);
			if (r < 70)
				s = {$urandom, $urandom};
			else if (r < 80)
				s = 64'($urandom_range(0, 15));
			else if (r < 90)
				s = ~64'($urandom_range(0, 15));
			else
				s = {1'b1, 63'($urandom_range(0, 3))};
			// hold off until every owed word is out, once mid-run and now and then
			drain = (i == RANDOM_ITEMS / 2) || ($urandom_range(0, 199) == 0);
			send_request(op, s, 1'b0, 64'h0, pick_gap(), drain);
		end
		in_valid <= 1'b0;

		// let the monitor book the last request, then drain
		@(posedge clk);
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
